// ----- rtl/core/grs_pkg.sv -----
// Shared widths and defaults for the group reversing stream block.
package grs_pkg;

  localparam int VALUE_W      = 32;
  localparam int SIZE_W       = 5;
  localparam int MAX_GROUP_DEF = 16;

  localparam logic [SIZE_W-1:0] GROUP_SIZE_RESET = SIZE_W'(1);

endpackage

// ----- rtl/core/grs_ifs.sv -----
// Handshake interfaces for the input, result and configuration channels.
interface grs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [grs_pkg::VALUE_W-1:0]   in_value;
  logic                                 in_final;

  modport source (output valid, output in_value, output in_final, input ready);
  modport sink (input valid, input in_value, input in_final, output ready);
endinterface

interface grs_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [grs_pkg::VALUE_W-1:0]   out_value;
  logic                                 run_end;
  logic                                 seq_end;

  modport source (output valid, output out_value, output run_end, output seq_end,
                  input ready);
  modport sink (input valid, input out_value, input run_end, input seq_end,
                output ready);
endinterface

interface grs_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [grs_pkg::SIZE_W-1:0]           group_size;

  modport source (output valid, output group_size, input ready);
  modport sink (input valid, input group_size, output ready);
endinterface

// ----- rtl/core/grs_mem.sv -----
// Group buffer: one write port and one read port with registered read data.
module grs_mem #(
  parameter int DEPTH = grs_pkg::MAX_GROUP_DEF
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [$clog2(DEPTH)-1:0]             waddr,
  input  logic signed [grs_pkg::VALUE_W-1:0]   wdata,
  input  logic                                 re,
  input  logic [$clog2(DEPTH)-1:0]             raddr,
  output logic signed [grs_pkg::VALUE_W-1:0]   rdata
);
  import grs_pkg::*;

  logic signed [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // The read register doubles as the result register: it holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/grs_ctrl.sv -----
// Fill counting, group decision and read sequencing for the group buffer.
module grs_ctrl #(
  parameter int MAX_GROUP = grs_pkg::MAX_GROUP_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_final,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [grs_pkg::SIZE_W-1:0]           cfg_size,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 run_end,
  output logic                                 seq_end,
  output logic                                 we,
  output logic [$clog2(MAX_GROUP)-1:0]         waddr,
  output logic                                 re,
  output logic [$clog2(MAX_GROUP)-1:0]         raddr
);
  import grs_pkg::*;

  localparam int IW = $clog2(MAX_GROUP);
  localparam int FW = $clog2(MAX_GROUP + 1);
  localparam int KW = (FW > SIZE_W) ? FW : SIZE_W;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic          state;
  logic [SIZE_W-1:0] group_size;
  logic [FW-1:0] fill;
  logic [FW-1:0] len;
  logic [IW-1:0] cnt;
  logic          rev;
  logic          fin;

  logic [KW-1:0] size_ext;
  logic [KW-1:0] k_eff;
  logic [FW-1:0] wfill;
  logic [FW-1:0] n;
  logic          emit_rev;
  logic          emit_any;
  logic          accept;
  logic          issue;
  logic          last;
  logic [FW-1:0] rev_addr;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;

  // Size zero acts as one; sizes above the buffer depth saturate.
  always_comb begin
    size_ext = KW'(group_size);
    if (size_ext == '0) begin
      k_eff = KW'(1);
    end else if (size_ext > KW'(MAX_GROUP)) begin
      k_eff = KW'(MAX_GROUP);
    end else begin
      k_eff = size_ext;
    end
  end

  assign wfill    = (fill >= FW'(MAX_GROUP)) ? FW'(MAX_GROUP - 1) : fill;
  assign n        = wfill + FW'(1);
  assign emit_rev = (KW'(n) >= k_eff);
  assign emit_any = emit_rev || in_final;

  assign we    = accept;
  assign waddr = wfill[IW-1:0];

  assign issue    = (state == ST_DRAIN) && (!out_valid || out_ready);
  assign last     = (FW'(cnt) == len - FW'(1));
  assign rev_addr = len - FW'(1) - FW'(cnt);
  assign re       = issue;
  assign raddr    = rev ? rev_addr[IW-1:0] : cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      group_size <= GROUP_SIZE_RESET;
      fill       <= '0;
      cnt        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        group_size <= cfg_size;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (emit_any) begin
              state <= ST_DRAIN;
              fill  <= '0;
              cnt   <= '0;
            end else begin
              fill <= n;
            end
          end
        end
        ST_DRAIN: begin
          if (issue) begin
            cnt <= cnt + IW'(1);
            if (last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (issue) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit_any) begin
      len <= n;
      rev <= emit_rev;
      fin <= in_final;
    end
    if (issue) begin
      run_end <= last;
      seq_end <= last && fin;
    end
  end

endmodule

// ----- rtl/core/group_reverse_stream.sv -----
// Top level of the group reversing stream block.
// Words are written into a buffer of MAX_GROUP entries as they arrive; an item that completes a
// group of group_size words, or that ends the sequence, starts a drain that reads its n held words
// back one per cycle, while the result side accepts, through the buffer's single read port, newest
// first for a complete group and in arrival order for a short trailing group. No new word is
// accepted until a drain is through, and the result side can stall a drain. A result waiting in
// the output register does not keep the next word from being accepted.
module group_reverse_stream #(
  parameter int MAX_GROUP = grs_pkg::MAX_GROUP_DEF
) (
  input logic       clk,
  input logic       rst,
  grs_in_if.sink    items,
  grs_out_if.source results,
  grs_cfg_if.sink   cfg
);
  import grs_pkg::*;

  localparam int IW = $clog2(MAX_GROUP);

  logic          we;
  logic          re;
  logic [IW-1:0] waddr;
  logic [IW-1:0] raddr;

  grs_ctrl #(
    .MAX_GROUP (MAX_GROUP)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .in_final  (items.in_final),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .cfg_size  (cfg.group_size),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .run_end   (results.run_end),
    .seq_end   (results.seq_end),
    .we        (we),
    .waddr     (waddr),
    .re        (re),
    .raddr     (raddr)
  );

  grs_mem #(
    .DEPTH (MAX_GROUP)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (items.in_value),
    .re    (re),
    .raddr (raddr),
    .rdata (results.out_value)
  );

endmodule

// ----- sim/group_reverse_stream_test.sv -----
// Self-checking testbench for group_reverse_stream: directed and random word streams.
module group_reverse_stream_test;
  timeunit 1ns;
  timeprecision 1ps;

  import grs_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 40;
  localparam int PHASE_COUNT   = 11;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [SIZE_W-1:0] PHASE_SIZES [PHASE_COUNT] =
    '{5'd1, 5'd2, 5'd3, 5'd5, 5'd8, 5'd16, 5'd31, 5'd12, 5'd0, 5'd4, 5'd7};

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               run_end;
    logic               seq_end;
  } word_result_t;

  // Mirrors the reversal buffer and holds the words the block still owes.
  class reverse_scoreboard;
    logic [VALUE_W-1:0] held_words [MAX_GROUP_DEF];
    int unsigned        held_count;
    logic [SIZE_W-1:0]  group_size;
    word_result_t       awaited [$];
    int                 failures;

    function new();
      held_count = 0;
      group_size = GROUP_SIZE_RESET;
      failures   = 0;
    endfunction

    function void set_group_size(logic [SIZE_W-1:0] size);
      group_size = size;
    endfunction

    function int unsigned span();
      int unsigned k;
      k = group_size;
      if (k == 0) begin
        k = 1;
      end
      if (k > MAX_GROUP_DEF) begin
        k = MAX_GROUP_DEF;
      end
      return k;
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) begin
        $display("ERROR at %0t: %s", $realtime, msg);
      end
    endfunction

    function void note_word(logic [VALUE_W-1:0] value, logic last_word);
      int unsigned k;
      int unsigned n;
      word_result_t r;
      k = span();
      if (held_count >= MAX_GROUP_DEF) begin
        held_count = MAX_GROUP_DEF - 1;
      end
      held_words[held_count] = value;
      held_count++;
      n = held_count;
      if (n >= k) begin
        // A full group, or a group the new size has already overrun, leaves newest first.
        for (int unsigned i = 0; i < n; i++) begin
          r.value   = held_words[n - 1 - i];
          r.run_end = (i == n - 1);
          r.seq_end = (i == n - 1) && last_word;
          awaited.push_back(r);
        end
        held_count = 0;
      end else if (last_word) begin
        for (int unsigned i = 0; i < n; i++) begin
          r.value   = held_words[i];
          r.run_end = (i == n - 1);
          r.seq_end = (i == n - 1);
          awaited.push_back(r);
        end
        held_count = 0;
      end
    endfunction

    function void check_word(logic [VALUE_W-1:0] value, logic run_end, logic seq_end);
      word_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result value=%h run_end=%b seq_end=%b",
                         value, run_end, seq_end));
        return;
      end
      want = awaited.pop_front();
      if (want.value !== value || want.run_end !== run_end || want.seq_end !== seq_end) begin
        report($sformatf({"expected value=%h run_end=%b seq_end=%b, ",
                          "got value=%h run_end=%b seq_end=%b"},
                         want.value, want.run_end, want.seq_end, value, run_end, seq_end));
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void close_out();
      if (awaited.size() != 0) begin
        report($sformatf("%0d results never arrived", awaited.size()));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic hold_results = 1'b0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   cycle_count = 0;

  reverse_scoreboard sb;

  grs_in_if  in_ch ();
  grs_out_if out_ch ();
  grs_cfg_if cfg_ch ();

  group_reverse_stream dut (
    .clk     (clk),
    .rst     (rst),
    .items   (in_ch),
    .results (out_ch),
    .cfg     (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= !hold_results && (int'($urandom_range(99)) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      sb.note_word(in_ch.in_value, in_ch.in_final);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      sb.check_word(out_ch.out_value, out_ch.run_end, out_ch.seq_end);
    end
  end

  function automatic logic [VALUE_W-1:0] random_word();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Valid stays high after a request is taken; only a gap or a drain lowers it.
  task automatic send_word(input logic [VALUE_W-1:0] value, input logic last_word);
    in_ch.valid    <= 1'b1;
    in_ch.in_value <= value;
    in_ch.in_final <= last_word;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic sender_gap();
    if (send_idle_pct != 0 && int'($urandom_range(99)) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while (int'($urandom_range(99)) < send_idle_pct);
    end
  endtask

  // The extra edge lets the monitor record the last accepted request first.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_group_size(input logic [SIZE_W-1:0] size);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.group_size <= size;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_group_size(size);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly complete sequences of random length; the phase may end inside a group,
  // so the next size setting meets a partly filled buffer.
  task automatic run_phase(input logic [SIZE_W-1:0] size, input int idle_pct,
                           input int stall_pct);
    int k;
    int seq_len;
    int sent;
    wait_drained();
    write_group_size(size);
    send_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    k = (size == 0) ? 1 : (size > MAX_GROUP_DEF) ? MAX_GROUP_DEF : size;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      seq_len = $urandom_range(1, 3 * k + 2);
      for (int pos = 0; pos < seq_len && sent < PHASE_ITEMS; pos++) begin
        sender_gap();
        send_word(random_word(), (pos == seq_len - 1) || ($urandom_range(15) == 0));
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.in_value = '0;
    in_ch.in_final = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.group_size = GROUP_SIZE_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Pass-through at the reset size, with both extreme words.
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'h8000_0000, 1'b1);
    wait_drained();
    // A size of zero behaves as one.
    write_group_size(5'd0);
    send_word('1, 1'b0);
    send_word('0, 1'b1);
    wait_drained();
    // Full group, short trailing group, then a group closed by the last word.
    write_group_size(5'd3);
    send_word(32'd1, 1'b0);
    send_word(32'd2, 1'b0);
    send_word(32'd3, 1'b0);
    send_word(32'd4, 1'b0);
    send_word(32'd5, 1'b1);
    send_word(32'd6, 1'b0);
    send_word(32'd7, 1'b0);
    send_word(32'd8, 1'b1);
    wait_drained();
    // Shrinking the size below the held count flushes everything on the next word.
    write_group_size(5'd4);
    send_word(32'd10, 1'b0);
    send_word(32'd11, 1'b0);
    send_word(32'd12, 1'b0);
    wait_drained();
    write_group_size(5'd2);
    send_word(32'd13, 1'b0);
    wait_drained();
    write_group_size(5'd16);
    send_word(32'd20, 1'b0);
    send_word(32'd21, 1'b1);
    wait_drained();
    // Sizes above the buffer depth saturate.
    write_group_size(5'd31);
    send_word(32'd30, 1'b1);
    wait_drained();

    // Results are held off while requests keep coming, so the block must stall its input.
    write_group_size(5'd4);
    fork
      begin
        hold_results <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results <= 1'b0;
      end
    join_none
    for (int i = 0; i < 60; i++) begin
      send_word(random_word(), (i % 9) == 8);
    end
    wait_drained();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      logic [SIZE_W-1:0] size;
      size = (p == PHASE_COUNT - 1) ? SIZE_W'($urandom_range(31)) : PHASE_SIZES[p];
      case (p % 4)
        0: run_phase(size, 0, 0);
        1: run_phase(size, 58, 0);
        2: run_phase(size, 0, 58);
        default: run_phase(size, 18, 18);
      endcase
    end

    wait_drained();
    repeat (20) @(posedge clk);
    sb.close_out();
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/grs_pkg.sv
rtl/core/grs_ifs.sv
rtl/core/grs_mem.sv
rtl/core/grs_ctrl.sv
rtl/core/group_reverse_stream.sv
sim/group_reverse_stream_test.sv
